[design/hbs_pkg.sv]
package hbs_pkg;

  localparam int unsigned GRID_WIDTH_DEF  = 16;
  localparam int unsigned GRID_HEIGHT_DEF = 16;

  localparam int unsigned STORE_DEPTH = 256;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned ACC_W       = 34;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic       clear;
    logic       load_w;
    logic [1:0] corner;
    logic       mul_en;
    logic       acc_en;
  } mac_ctrl_t;

endpackage

[design/hbs_store.sv]
module hbs_store
  import hbs_pkg::*;
(
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic signed [HEIGHT_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic signed [HEIGHT_W-1:0] rd_data
);

  logic signed [HEIGHT_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[design/hbs_mac.sv]
module hbs_mac
  import hbs_pkg::*;
(
  input  logic                       clk,
  input  mac_ctrl_t                  ctrl,
  input  logic [FRAC_W-1:0]          fu,
  input  logic [FRAC_W-1:0]          fv,
  input  logic signed [HEIGHT_W-1:0] rd_data,
  output logic signed [HEIGHT_W-1:0] result
);

  logic [FRAC_W:0]             wu;
  logic [FRAC_W:0]             wv;
  logic [2*FRAC_W+1:0]         wfull;
  logic [WEIGHT_W-1:0]         wreg;
  logic signed [ACC_W-1:0]     mult;
  logic signed [ACC_W-1:0]     prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     acc_adj;

  // corner bit 0 picks the right column, bit 1 the lower row
  always_comb begin
    wu    = ctrl.corner[0] ? {1'b0, fu} : (9'd256 - {1'b0, fu});
    wv    = ctrl.corner[1] ? {1'b0, fv} : (9'd256 - {1'b0, fv});
    wfull = {9'd0, wu} * {9'd0, wv};
    mult  = $signed({1'b0, wreg}) * rd_data;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_w) begin
      wreg <= wfull[WEIGHT_W-1:0];
    end
    if (ctrl.mul_en) begin
      prod <= mult;
    end
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.acc_en) begin
      acc <= acc + prod;
    end
  end

  // truncate toward zero
  always_comb begin
    acc_adj = acc + (acc[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
    result  = acc_adj[2*FRAC_W+HEIGHT_W-1:2*FRAC_W];
  end

endmodule

[design/heightmap_bilinear_sampler.sv]
// Bilinear height map sampler over a 256-entry store of signed Q8.8 heights.
// A write beat stores one entry and gives no result. A sample beat reads
// its four corner entries one after another through the single read port
// of the store, weighting and accumulating each in the shared
// multiply-accumulate unit before its result is offered. An out-of-range
// sample skips the reads and gives a zero result. A new beat is accepted
// once the previous sample has moved into the output register, even if
// that result has not yet been taken. Entries read before they were ever
// written give undefined results.
module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = GRID_HEIGHT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       operation,
  input  logic [7:0]                 entry_index,
  input  logic signed [15:0]         height_value,
  input  logic signed [15:0]         coord_u,
  input  logic signed [15:0]         coord_v,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [15:0]         height_result,
  output logic                       out_of_range
);

  localparam logic [7:0] HALF_W   = 8'(GRID_WIDTH / 2);
  localparam logic [7:0] HALF_H   = 8'(GRID_HEIGHT / 2);
  localparam logic [7:0] ROW_STEP = 8'(GRID_WIDTH % STORE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [2:0] STEP_LAST_READ = 3'd3;
  localparam logic [2:0] STEP_LAST_MUL  = 3'd4;
  localparam logic [2:0] STEP_LAST      = 3'd5;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [2:0]              step;
  logic [ADDR_W-1:0]       base;
  logic [FRAC_W-1:0]       fu;
  logic [FRAC_W-1:0]       fv;
  logic                    oor;

  logic                    accept;
  logic                    sample_in;
  logic                    oor_in;
  logic [15:0]             row_off;
  logic [ADDR_W-1:0]       base_in;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [HEIGHT_W-1:0] rd_data;
  logic signed [HEIGHT_W-1:0] mac_result;
  logic                    out_free;
  mac_ctrl_t               ctrl;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign sample_in = (operation == OP_SAMPLE);
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    oor_in  = coord_u[15] || coord_v[15] ||
              ({1'b0, coord_u[14:8]} >= HALF_W) ||
              ({1'b0, coord_v[14:8]} >= HALF_H);
    row_off = {8'd0, coord_v[14:8], 1'b0} * {8'd0, ROW_STEP};
    base_in = row_off[7:0] + {coord_u[14:8], 1'b0};
  end

  always_comb begin
    case (step[1:0])
      2'd0:    rd_addr = base;
      2'd1:    rd_addr = base + 8'd1;
      2'd2:    rd_addr = base + ROW_STEP;
      default: rd_addr = base + ROW_STEP + 8'd1;
    endcase
  end

  always_comb begin
    ctrl.clear  = accept && sample_in;
    ctrl.corner = step[1:0];
    ctrl.load_w = (state == ST_RUN) && (step <= STEP_LAST_READ);
    ctrl.mul_en = (state == ST_RUN) && (step != 3'd0) && (step <= STEP_LAST_MUL);
    ctrl.acc_en = (state == ST_RUN) && (step >= 3'd2);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && sample_in) begin
          state_next = oor_in ? ST_FIN : ST_RUN;
        end
      end
      ST_RUN: begin
        if (step == STEP_LAST) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        step <= step + 3'd1;
      end else begin
        step <= '0;
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && sample_in) begin
      base <= base_in;
      fu   <= coord_u[7:0];
      fv   <= coord_v[7:0];
      oor  <= oor_in;
    end
    if (state == ST_FIN && out_free) begin
      height_result <= oor ? 16'sd0 : mac_result;
      out_of_range  <= oor;
    end
  end

  hbs_store u_store (
    .clk     (clk),
    .wr_en   (accept && !sample_in),
    .wr_addr (entry_index),
    .wr_data (height_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hbs_mac u_mac (
    .clk     (clk),
    .ctrl    (ctrl),
    .fu      (fu),
    .fv      (fv),
    .rd_data (rd_data),
    .result  (mac_result)
  );

endmodule

[design/hbs_checker.sv]
module hbs_checker
  import hbs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               operation,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] height_result,
  input logic               out_of_range
);

  // a waiting result beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(height_result) && $stable(out_of_range))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> height_result == 16'sd0)
    else $error("out-of-range result not zero");

  // a sample keeps the input closed for at least the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_SAMPLE |=> !in_ready)
    else $error("input open right after a sample");

  // a write never produces a result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && operation == OP_WRITE && !out_valid |=> !out_valid)
    else $error("result after a write beat");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .operation     (operation),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .height_result (height_result),
  .out_of_range  (out_of_range)
);
